### hw/rtl/lbm_pkg.sv
// ----------------------------------------------------------------------------
// LED bar meter package
// Shared widths, register indexes, color codes and the reciprocal constants
// used for the divisions by constants.
// ----------------------------------------------------------------------------
package lbm_pkg;

    localparam int LBM_LED_COUNT = 16;

    localparam int LEVEL_W    = 16;
    localparam int COLORS_W   = 32;
    localparam int SEG_W      = 5;
    localparam int MAX_SHOWN  = 16;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIM        = 3'd4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef logic [1:0] color_t;
    localparam color_t COLOR_OFF    = 2'd0;
    localparam color_t COLOR_GREEN  = 2'd1;
    localparam color_t COLOR_YELLOW = 2'd2;
    localparam color_t COLOR_RED    = 2'd3;

    // Exact floor division of a 16-bit value by 30 and by 80 through a
    // rounded-up reciprocal: 2^23 exceeds 2^16 times either divisor.
    localparam int DECAY_PEAK_DIV = 30;
    localparam int DECAY_SPAN_DIV = 80;
    localparam int RECIP_SHIFT    = 23;
    localparam int PEAK_RECIP_W   = 19;
    localparam int SPAN_RECIP_W   = 17;
    localparam logic [PEAK_RECIP_W-1:0] PEAK_DIV_RECIP =
        PEAK_RECIP_W'(((1 << RECIP_SHIFT) + DECAY_PEAK_DIV - 1) / DECAY_PEAK_DIV);
    localparam logic [SPAN_RECIP_W-1:0] SPAN_DIV_RECIP =
        SPAN_RECIP_W'(((1 << RECIP_SHIFT) + DECAY_SPAN_DIV - 1) / DECAY_SPAN_DIV);
    localparam int PEAK_Q_W = 12;
    localparam int SPAN_Q_W = 10;

    // Segment thresholds: 2^22 exceeds 2^16 times the largest segment count.
    localparam int THR_SHIFT  = 22;
    localparam int THR_MULT_W = 23;

    localparam logic [LEVEL_W-1:0] RANGE_LOW_RST  = 16'd0;
    localparam logic [LEVEL_W-1:0] RANGE_HIGH_RST = 16'd100;
    localparam logic [LEVEL_W-1:0] YELLOW_RST     = 16'd60;
    localparam logic [LEVEL_W-1:0] RED_RST        = 16'd80;
    localparam logic [LEVEL_W-1:0] LEVEL_RST      = 16'd1;

    typedef struct packed {
        logic [LEVEL_W-1:0] range_low;
        logic [LEVEL_W-1:0] range_high;
        logic [LEVEL_W-1:0] yellow_level;
        logic [LEVEL_W-1:0] red_level;
        logic               dim_mode;
    } lbm_cfg_t;

endpackage

### hw/rtl/lbm_if.sv
// ----------------------------------------------------------------------------
// LED bar meter channels
// Valid/ready channels for level items in and bar items out.
// ----------------------------------------------------------------------------
interface lbm_in_if;
    import lbm_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, opcode, level, input ready);
    modport sink   (input valid, opcode, level, output ready);
endinterface

interface lbm_out_if;
    import lbm_pkg::*;

    logic                valid;
    logic                ready;
    logic [COLORS_W-1:0] segment_colors;
    logic [SEG_W-1:0]    peak_segment;
    logic [LEVEL_W-1:0]  held_peak;
    logic                dim_out;

    modport source (output valid, segment_colors, peak_segment, held_peak, dim_out,
                    input ready);
    modport sink   (input valid, segment_colors, peak_segment, held_peak, dim_out,
                    output ready);
endinterface

### hw/rtl/lbm_scale.sv
// ----------------------------------------------------------------------------
// LED bar meter scale
// Registers the segment thresholds and their base colors, and gives the span
// part of the decay step, all derived from the configuration registers.
// ----------------------------------------------------------------------------
module lbm_scale #(
    parameter int LED_COUNT = lbm_pkg::LBM_LED_COUNT
) (
    input  logic                         clk,
    input  lbm_pkg::lbm_cfg_t            cfg,
    output logic [lbm_pkg::LEVEL_W-1:0]  thr_level [LED_COUNT],
    output lbm_pkg::color_t              lane_color [LED_COUNT],
    output logic [lbm_pkg::SPAN_Q_W-1:0] span_q
);
    import lbm_pkg::*;

    localparam int THR_PROD_W  = LEVEL_W + THR_MULT_W;
    localparam int SPAN_PROD_W = LEVEL_W + SPAN_RECIP_W;

    logic [LEVEL_W-1:0]     span;
    logic [SPAN_PROD_W-1:0] span_prod;
    logic [LEVEL_W-1:0]     thr_reg [LED_COUNT];
    color_t                 color_reg [LED_COUNT];

    // An inverted range collapses every threshold onto range_low.
    assign span      = (cfg.range_high > cfg.range_low) ? (cfg.range_high - cfg.range_low)
                                                         : '0;
    assign span_prod = SPAN_PROD_W'(span) * SPAN_PROD_W'(SPAN_DIV_RECIP);

    // The decay step of an item accepted right after a register write must
    // already see the new span, so this part stays combinational.
    assign span_q = span_prod[RECIP_SHIFT +: SPAN_Q_W];

    for (genvar i = 0; i < LED_COUNT; i++)
    begin : g_lane
        localparam logic [THR_MULT_W-1:0] LANE_MULT =
            THR_MULT_W'(((i << THR_SHIFT) + LED_COUNT - 1) / LED_COUNT);

        logic [THR_PROD_W-1:0] lane_prod;
        logic [LEVEL_W-1:0]    lane_thr;
        color_t                lane_base;

        assign lane_prod = THR_PROD_W'(span) * THR_PROD_W'(LANE_MULT);
        assign lane_thr  = cfg.range_low + lane_prod[THR_SHIFT +: LEVEL_W];

        always_comb
        begin
            if (lane_thr > cfg.red_level)
            begin
                lane_base = COLOR_RED;
            end
            else if (lane_thr > cfg.yellow_level)
            begin
                lane_base = COLOR_YELLOW;
            end
            else
            begin
                lane_base = COLOR_GREEN;
            end
        end

        always_ff @(posedge clk)
        begin
            thr_reg[i]   <= lane_thr;
            color_reg[i] <= lane_base;
        end

        assign thr_level[i]  = thr_reg[i];
        assign lane_color[i] = color_reg[i];
    end

endmodule

### hw/rtl/led_bar_meter_peak_hold_core.sv
// ----------------------------------------------------------------------------
// LED bar meter with peak hold
// Level meter bar with a decaying peak-hold segment and an APB register port.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output side does not stall,
// either a level sample or a peak decay tick, and returns exactly one bar item
// for each. The level and peak registers are updated at the edge that accepts
// an item; the bar is built from them and loaded into the output register when
// that register is empty or its item is being taken. The rate of one item per
// cycle is set by the peak register update, which holds the whole decay step
// (multiplies by reciprocals, adds and compares) in combinational logic.
// Segment thresholds and their colors are recomputed from the registers every
// cycle, so a register write is in effect for any item accepted after it.
module led_bar_meter_peak_hold_core #(
    parameter int LED_COUNT = lbm_pkg::LBM_LED_COUNT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    lbm_in_if.sink                         sample_in,
    lbm_out_if.source                      bar_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lbm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lbm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lbm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lbm_pkg::*;

    localparam int SHOWN       = (LED_COUNT < MAX_SHOWN) ? LED_COUNT : MAX_SHOWN;
    localparam int PEAK_PROD_W = LEVEL_W + PEAK_RECIP_W;

    lbm_cfg_t               cfg_reg;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   reg_idx;

    logic [LEVEL_W-1:0]     thr_level [LED_COUNT];
    color_t                 lane_color [LED_COUNT];
    logic [SPAN_Q_W-1:0]    span_q;

    logic [LEVEL_W-1:0]     cur_reg;
    logic [LEVEL_W-1:0]     cur_next;
    logic [LEVEL_W-1:0]     peak_reg;
    logic [LEVEL_W-1:0]     peak_next;
    logic [LEVEL_W-1:0]     peak_excess;
    logic [PEAK_PROD_W-1:0] excess_prod;
    logic [LEVEL_W:0]       drop;
    logic [LEVEL_W-1:0]     decayed;

    logic                   accept_in;
    logic                   load_out;
    logic                   pend_reg;
    logic                   pend_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic [LED_COUNT-1:0]   peak_le;
    logic [LED_COUNT-1:0]   peak_le_up;
    logic [LED_COUNT-1:0]   is_peak;
    logic [LED_COUNT-1:0]   above_cur;
    logic [SEG_W-1:0]       seg_next;
    logic [COLORS_W-1:0]    colors_next;

    logic [COLORS_W-1:0]    colors_reg;
    logic [SEG_W-1:0]       seg_reg;
    logic [LEVEL_W-1:0]     held_reg;
    logic                   dim_reg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_low    <= RANGE_LOW_RST;
            cfg_reg.range_high   <= RANGE_HIGH_RST;
            cfg_reg.yellow_level <= YELLOW_RST;
            cfg_reg.red_level    <= RED_RST;
            cfg_reg.dim_mode     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_RANGE_LOW:  cfg_reg.range_low    <= pwdata[LEVEL_W-1:0];
                REG_RANGE_HIGH: cfg_reg.range_high   <= pwdata[LEVEL_W-1:0];
                REG_YELLOW:     cfg_reg.yellow_level <= pwdata[LEVEL_W-1:0];
                REG_RED:        cfg_reg.red_level    <= pwdata[LEVEL_W-1:0];
                REG_DIM:        cfg_reg.dim_mode     <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RANGE_LOW:  prdata = CFG_DATA_W'(cfg_reg.range_low);
            REG_RANGE_HIGH: prdata = CFG_DATA_W'(cfg_reg.range_high);
            REG_YELLOW:     prdata = CFG_DATA_W'(cfg_reg.yellow_level);
            REG_RED:        prdata = CFG_DATA_W'(cfg_reg.red_level);
            REG_DIM:        prdata = CFG_DATA_W'(cfg_reg.dim_mode);
            default:        prdata = '0;
        endcase
    end

    lbm_scale #(
        .LED_COUNT (LED_COUNT)
    ) u_scale (
        .clk        (clk),
        .cfg        (cfg_reg),
        .thr_level  (thr_level),
        .lane_color (lane_color),
        .span_q     (span_q)
    );

    // ---------------- handshake ----------------
    assign load_out        = pend_reg && (!out_valid_reg || bar_out.ready);
    assign sample_in.ready = !pend_reg || load_out;
    assign accept_in       = sample_in.valid && sample_in.ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (accept_in)
        begin
            pend_next = 1'b1;
        end
        else if (load_out)
        begin
            pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (bar_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------- peak hold and decay ----------------
    assign peak_excess = peak_reg - cfg_reg.range_low;
    assign excess_prod = PEAK_PROD_W'(peak_excess) * PEAK_PROD_W'(PEAK_DIV_RECIP);

    always_comb
    begin
        drop = (LEVEL_W + 1)'(excess_prod[RECIP_SHIFT +: PEAK_Q_W]) + (LEVEL_W + 1)'(span_q);
        if (drop == '0)
        begin
            drop = (LEVEL_W + 1)'(1);
        end

        if (peak_reg <= cfg_reg.range_low)
        begin
            decayed = cfg_reg.range_low;
        end
        else if ((LEVEL_W + 1)'(peak_excess) <= drop)
        begin
            decayed = cfg_reg.range_low;
        end
        else
        begin
            decayed = peak_reg - drop[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        cur_next  = cur_reg;
        peak_next = peak_reg;
        if (sample_in.opcode == OP_TICK)
        begin
            peak_next = decayed;
        end
        else
        begin
            cur_next  = sample_in.level;
            peak_next = (peak_reg < sample_in.level) ? sample_in.level : peak_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= LEVEL_RST;
            peak_reg      <= LEVEL_RST;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (accept_in)
            begin
                cur_reg  <= cur_next;
                peak_reg <= peak_next;
            end
        end
    end

    // ---------------- bar ----------------
    // Thresholds never decrease along the bar, so the compares against the
    // peak form a thermometer code and the peak is its top set bit.
    always_comb
    begin
        for (int i = 0; i < LED_COUNT; i++)
        begin
            peak_le[i]   = thr_level[i] <= peak_reg;
            above_cur[i] = thr_level[i] > cur_reg;
        end
    end

    assign peak_le_up = peak_le >> 1;
    assign is_peak    = peak_le & ~peak_le_up;

    always_comb
    begin
        seg_next = SEG_W'(LED_COUNT);
        for (int i = 0; i < LED_COUNT; i++)
        begin
            if (peak_le[i])
            begin
                seg_next = SEG_W'(i);
            end
        end

        colors_next = '0;
        for (int i = 0; i < SHOWN; i++)
        begin
            if (above_cur[i] && !is_peak[i])
            begin
                colors_next[2*i +: 2] = COLOR_OFF;
            end
            else
            begin
                colors_next[2*i +: 2] = lane_color[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            colors_reg <= colors_next;
            seg_reg    <= seg_next;
            held_reg   <= peak_reg;
            dim_reg    <= cfg_reg.dim_mode;
        end
    end

    assign bar_out.valid          = out_valid_reg;
    assign bar_out.segment_colors = colors_reg;
    assign bar_out.peak_segment   = seg_reg;
    assign bar_out.held_peak      = held_reg;
    assign bar_out.dim_out        = dim_reg;

endmodule

### hw/rtl/lbm_checker.sv
// ----------------------------------------------------------------------------
// LED bar meter checker
// Port-level assertions on the bar channel, bound to the top level.
// ----------------------------------------------------------------------------
module lbm_checker #(
    parameter int LED_COUNT = lbm_pkg::LBM_LED_COUNT
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [lbm_pkg::COLORS_W-1:0] segment_colors,
    input logic [lbm_pkg::SEG_W-1:0]    peak_segment,
    input logic [lbm_pkg::LEVEL_W-1:0]  held_peak,
    input logic                         dim_out
);
    import lbm_pkg::*;

    logic [1:0] owed_reg;
    logic [1:0] owed_next;

    // Items accepted whose bar item has not been taken yet.
    always_comb
    begin
        owed_next = owed_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            owed_next = owed_reg + 2'd1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            owed_next = owed_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg <= 2'd0;
        end
        else
        begin
            owed_reg <= owed_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(segment_colors)
            && $stable(peak_segment) && $stable(held_peak) && $stable(dim_out))
        else $error("bar item changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> owed_reg != 2'd0)
        else $error("bar item shown without an accepted item");

    a_owed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg != 2'd3)
        else $error("more items in flight than the pipeline holds");

    a_peak_lit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (LED_COUNT < 32) && (peak_segment < SEG_W'(MAX_SHOWN))
            && (32'(peak_segment) < LED_COUNT)
            |-> ((segment_colors >> (6'(peak_segment) << 1)) & 32'd3) != 32'd0)
        else $error("peak segment is dark");

    // Apart from the peak marker, the lit part of the bar has no gaps.
    for (genvar i = 1; i < MAX_SHOWN; i++)
    begin : g_bar
        a_bar_solid: assert property (@(posedge clk) disable iff (!rst_n)
            out_valid && (segment_colors[2*i +: 2] != 2'd0) && (peak_segment != SEG_W'(i))
                |-> segment_colors[2*(i-1) +: 2] != 2'd0)
            else $error("gap in the lit bar");
    end

endmodule

bind led_bar_meter_peak_hold_core lbm_checker #(
    .LED_COUNT (LED_COUNT)
) u_lbm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample_in.valid),
    .in_ready       (sample_in.ready),
    .out_valid      (bar_out.valid),
    .out_ready      (bar_out.ready),
    .segment_colors (bar_out.segment_colors),
    .peak_segment   (bar_out.peak_segment),
    .held_peak      (bar_out.held_peak),
    .dim_out        (bar_out.dim_out)
);
